// ----- hdl/bitmap_page_run_allocator_core_macros.svh -----
// Assertion helpers for the allocator core.
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_CORE_MACROS_SVH

// The condition must never hold outside reset.
`define BPRA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bpra check failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BPRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpra check failed");

`endif

// ----- hdl/bpra_pkg.sv -----
package bpra_pkg;

   localparam int ADDR_W = 32;
   localparam int COUNT_W = 7;
   localparam int POOL_CNT_W = 13;

   localparam logic [ADDR_W-1:0] HEAP_VBASE_RESET = 32'hC010_0000;
   localparam logic [ADDR_W-1:0] KERN_PBASE_RESET = 32'h0020_0000;

   typedef enum logic [1:0] {
      CSR_HEAP_VBASE = 2'd0,
      CSR_KERN_PBASE = 2'd1,
      CSR_POOL_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_MAPPED   = 2'd0,
      ST_NO_VIRT  = 2'd1,
      ST_NO_PHYS  = 2'd2,
      ST_TOO_BIG  = 2'd3
   } status_type;

endpackage

// ----- hdl/bpra_bitmap.sv -----
module bpra_bitmap #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic                     rd_data
);
   logic mem_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/bpra_addr.sv -----
module bpra_addr #(
   parameter int IDX_W = 12,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                          clock,
   input  logic [IDX_W-1:0]              idx,
   input  logic [bpra_pkg::ADDR_W-1:0]   base,
   output logic [bpra_pkg::ADDR_W-1:0]   addr
);
   import bpra_pkg::*;

   logic [ADDR_W-1:0] prod_ff;
   logic [ADDR_W-1:0] prod_in;

   // Product is registered; the base is added on the following cycle.
   assign prod_in = ADDR_W'(ADDR_W'(idx) * ADDR_W'(PAGE_BYTES));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign addr = base + prod_ff;
endmodule

// ----- hdl/bitmap_page_run_allocator_core.sv -----
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | tdata: page_count; tuser: kind
// rsp     | out       | rsp_tvalid/tready    | tdata: va, pa, status; tlast: last
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// After reset both bitmaps are cleared, one entry per cycle; requests are
// not taken meanwhile, configuration writes are.
// A request is worked one at a time: a virtual scan, then marking the run
// one page at a time. Each page then needs a physical scan from the
// low-water mark, the shared multiply-add unit and the response transfer.
// A stalled response holds the sequencer until the transfer completes.
module bitmap_page_run_allocator_core #(
   parameter int POOL_PAGES = 4096,
   parameter int MAX_RUN    = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] page_count, [7] zero fill
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] virtual_address,
                                    // [63:32] physical_address,
                                    // [65:64] status, [71:66] zero fill
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bpra_pkg::*;

   localparam int IW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int CW = $clog2(POOL_PAGES + 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_VSCAN = 8'b0000_0100,
      S_VMARK = 8'b0000_1000,
      S_PSCAN = 8'b0001_0000,
      S_MULV  = 8'b0010_0000,
      S_MULP  = 8'b0100_0000,
      S_SUM   = 8'b1000_0000
   } state_type;

   // Response-pending is its own flag so that S_SUM and error paths share it.
   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      hvb_ff, kpb_ff;
   logic [POOL_CNT_W-1:0]  pool_ff;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [CW-1:0]          hint_ff, hint_in;
   logic                   rdv_ff, rdv_in;
   logic [IW-1:0]          rdi_ff, rdi_in;
   logic [COUNT_W-1:0]     run_ff, run_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [COUNT_W-1:0]     k_ff, k_in;
   logic [IW-1:0]          start_ff, start_in;
   logic [IW-1:0]          ppage_ff, ppage_in;
   logic [ADDR_W-1:0]      va_ff, va_in;
   logic                   out_ff, out_in;
   logic [ADDR_W-1:0]      rva_ff, rva_in, rpa_ff, rpa_in;
   status_type             rst_ff, rst_in;
   logic                   rlast_ff, rlast_in;

   logic [CW-1:0]          limit;
   logic [POOL_CNT_W-1:0]  masked;
   logic                   issue;
   logic [IW-1:0]          vpage;
   logic                   v_we, v_wd, v_rd;
   logic [IW-1:0]          v_wa;
   logic                   p_we, p_rd;
   logic [IW-1:0]          p_wa;
   logic [IW-1:0]          mul_idx;
   logic [ADDR_W-1:0]      mul_base, mul_addr;
   logic                   rsp_err;

   // Usable pages: count rounded down to a multiple of eight, capped at pool size.
   assign masked = {pool_ff[POOL_CNT_W-1:3], 3'b000};
   assign limit  = (32'(masked) > POOL_PAGES) ? CW'(POOL_PAGES) : CW'(masked);
   assign issue  = scan_ff < limit;
   assign vpage  = start_ff + IW'(k_ff);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_tvalid = out_ff;
   assign rsp_tdata  = {6'b0, rst_ff, rpa_ff, rva_ff};
   assign rsp_tlast  = rlast_ff;
   assign rsp_err    = rsp_tvalid && (rst_ff != ST_MAPPED);

   always_ff @(posedge clock) begin
      if (reset) begin
         hvb_ff  <= HEAP_VBASE_RESET;
         kpb_ff  <= KERN_PBASE_RESET;
         pool_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEAP_VBASE: hvb_ff <= csr_data;
            CSR_KERN_PBASE: kpb_ff <= csr_data;
            CSR_POOL_COUNT: pool_ff <= csr_data[POOL_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   bpra_bitmap #(.DEPTH(POOL_PAGES)) u_vmap (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(scan_ff[IW-1:0]), .rd_data(v_rd)
   );

   bpra_bitmap #(.DEPTH(POOL_PAGES)) u_pmap (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(state_ff != S_CLEAR),
      .rd_addr(scan_ff[IW-1:0]), .rd_data(p_rd)
   );

   bpra_addr #(.IDX_W(IW), .PAGE_BYTES(PAGE_BYTES)) u_addr (
      .clock(clock), .idx(mul_idx), .base(mul_base), .addr(mul_addr)
   );

   assign mul_idx  = (state_ff == S_MULV) ? vpage : ppage_ff;
   assign mul_base = (state_ff == S_MULP) ? hvb_ff : kpb_ff;

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      hint_in  = hint_ff;
      rdv_in   = 1'b0;
      rdi_in   = scan_ff[IW-1:0];
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      start_in = start_ff;
      ppage_in = ppage_ff;
      va_in    = va_ff;
      out_in   = out_ff;
      rva_in   = rva_ff;
      rpa_in   = rpa_ff;
      rst_in   = rst_ff;
      rlast_in = rlast_ff;
      v_we     = 1'b0;
      v_wa     = vpage;
      v_wd     = 1'b1;
      p_we     = 1'b0;
      p_wa     = rdi_ff;

      // A pending response blocks the sequencer until it is transferred.
      if (out_ff) begin
         if (rsp_tready) begin
            out_in = 1'b0;
            if (!rlast_ff) begin
               k_in     = k_ff + 1'b1;
               scan_in  = hint_ff;
               state_in = S_PSCAN;
            end
         end
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               v_we    = 1'b1;
               v_wd    = 1'b0;
               v_wa    = scan_ff[IW-1:0];
               p_we    = 1'b1;
               p_wa    = scan_ff[IW-1:0];
               scan_in = scan_ff + 1'b1;
               if (scan_ff == CW'(POOL_PAGES - 1)) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  rva_in   = '0;
                  rpa_in   = '0;
                  rlast_in = 1'b1;
                  cnt_in   = req_tdata[COUNT_W-1:0];
                  if (req_tdata[COUNT_W-1:0] == '0 ||
                      req_tdata[COUNT_W-1:0] > COUNT_W'(MAX_RUN)) begin
                     rst_in = ST_TOO_BIG;
                     out_in = 1'b1;
                  end else if (req_tuser) begin
                     rst_in = ST_NO_VIRT;
                     out_in = 1'b1;
                  end else begin
                     scan_in  = '0;
                     run_in   = '0;
                     state_in = S_VSCAN;
                  end
               end
            end
            S_VSCAN: begin
               // Reads are pipelined one ahead of the run check.
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
                  rdv_in  = 1'b1;
               end
               if (rdv_ff) begin
                  if (v_rd) begin
                     run_in = '0;
                  end else if (run_ff + 1'b1 == cnt_ff) begin
                     start_in = rdi_ff - IW'(cnt_ff - 1'b1);
                     k_in     = '0;
                     rdv_in   = 1'b0;
                     state_in = S_VMARK;
                  end else begin
                     run_in = run_ff + 1'b1;
                  end
               end else if (!issue) begin
                  rva_in   = '0;
                  rpa_in   = '0;
                  rst_in   = ST_NO_VIRT;
                  rlast_in = 1'b1;
                  out_in   = 1'b1;
                  state_in = S_IDLE;
               end
            end
            S_VMARK: begin
               v_we = 1'b1;
               if (k_ff + 1'b1 == cnt_ff) begin
                  k_in     = '0;
                  scan_in  = hint_ff;
                  state_in = S_PSCAN;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            S_PSCAN: begin
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
                  rdv_in  = 1'b1;
               end
               if (rdv_ff && !p_rd) begin
                  p_we     = 1'b1;
                  ppage_in = rdi_ff;
                  hint_in  = CW'(rdi_ff) + 1'b1;
                  rdv_in   = 1'b0;
                  state_in = S_MULV;
               end else if (!rdv_ff && !issue) begin
                  rva_in   = '0;
                  rpa_in   = '0;
                  rst_in   = ST_NO_PHYS;
                  rlast_in = 1'b1;
                  out_in   = 1'b1;
                  state_in = S_IDLE;
               end
            end
            S_MULV: begin
               state_in = S_MULP;
            end
            S_MULP: begin
               va_in    = mul_addr;
               state_in = S_SUM;
            end
            S_SUM: begin
               rva_in   = va_ff;
               rpa_in   = mul_addr;
               rst_in   = ST_MAPPED;
               rlast_in = (k_ff + 1'b1 == cnt_ff);
               out_in   = 1'b1;
               state_in = (k_ff + 1'b1 == cnt_ff) ? S_IDLE : S_PSCAN;
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff  <= '0;
         hint_ff  <= '0;
         rdv_ff   <= 1'b0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         hint_ff  <= hint_in;
         rdv_ff   <= rdv_in;
         out_ff   <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      rdi_ff   <= rdi_in;
      run_ff   <= run_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      start_ff <= start_in;
      ppage_ff <= ppage_in;
      va_ff    <= va_in;
      rva_ff   <= rva_in;
      rpa_ff   <= rpa_in;
      rst_ff   <= rst_in;
      rlast_ff <= rlast_in;
   end

`include "bitmap_page_run_allocator_core_macros.svh"

   `BPRA_ASSERT_NEVER(a_no_overlap, clock, reset, req_tready && rsp_tvalid)
   `BPRA_ASSERT_NEVER(a_clear_blocks, clock, reset, (state_ff == S_CLEAR) && req_tready)
   `BPRA_ASSERT_IMPL(a_err_last, clock, reset, rsp_err, rsp_tlast)
   `BPRA_ASSERT_IMPL(a_err_zero, clock, reset, rsp_err, (rva_ff == '0) && (rpa_ff == '0))

endmodule
